>>> rtl/gtr_pkg.sv
package gtr_pkg;

  // store selection for the read port
  localparam logic [1:0] SRC_IND = 2'd0;
  localparam logic [1:0] SRC_SPC = 2'd1;
  localparam logic [1:0] SRC_WRD = 2'd2;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic       load;
    logic       mod_step;
    logic [2:0] mod_bit;
    logic       rd_en;
    logic [1:0] rd_src;
    logic [5:0] rd_idx;
    logic       emit_nl;
    logic       emit_mem;
    logic       emit_last;
    logic       apply;
  } gtr_cmd_t;

  // emission plan and status back to the sequencer
  typedef struct packed {
    logic       nl1;
    logic       a_ind;
    logic [5:0] a_n;
    logic [5:0] w_n;
    logic       nl2;
    logic       is_tab;
    logic       out_free;
  } gtr_stat_t;

endpackage

>>> rtl/gtr_ctrl.sv
module gtr_ctrl
  import gtr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gtr_stat_t stat,
  output gtr_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_NL1   = 4'd2;
  localparam logic [3:0] S_ARD   = 4'd3;
  localparam logic [3:0] S_AOUT  = 4'd4;
  localparam logic [3:0] S_WRD   = 4'd5;
  localparam logic [3:0] S_WOUT  = 4'd6;
  localparam logic [3:0] S_NL2   = 4'd7;
  localparam logic [3:0] S_APPLY = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [3:0] from_n1, from_a, from_w, from_n2;
  logic [5:0] idx_inc;

  // first non-empty phase from each point of the run
  assign from_n2 = stat.nl2 ? S_NL2 : S_APPLY;
  assign from_w  = (stat.w_n != 6'd0) ? S_WRD : from_n2;
  assign from_a  = (stat.a_n != 6'd0) ? S_ARD : from_w;
  assign from_n1 = stat.nl1 ? S_NL1 : from_a;
  assign idx_inc = idx_r + 6'd1;

  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.mod_bit   = ~cnt_r;
    cmd.rd_idx    = idx_r;
    cmd.rd_src    = stat.a_ind ? SRC_IND : SRC_SPC;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 3'd0;
          idx_nxt   = 6'd0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (!stat.is_tab || cnt_r == 3'd7) begin
          cnt_nxt   = 3'd0;
          state_nxt = from_n1;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_NL1: begin
        if (stat.out_free) begin
          cmd.emit_nl   = 1'b1;
          cmd.emit_last = (stat.a_n == 6'd0) && (stat.w_n == 6'd0) && !stat.nl2;
          idx_nxt       = 6'd0;
          state_nxt     = from_a;
        end
      end
      S_ARD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_AOUT;
      end
      S_AOUT: begin
        if (stat.out_free) begin
          cmd.emit_mem  = 1'b1;
          cmd.emit_last = (idx_inc == stat.a_n) && (stat.w_n == 6'd0) && !stat.nl2;
          if (idx_inc == stat.a_n) begin
            idx_nxt   = 6'd0;
            state_nxt = from_w;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_ARD;
          end
        end
      end
      S_WRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = SRC_WRD;
        state_nxt  = S_WOUT;
      end
      S_WOUT: begin
        if (stat.out_free) begin
          cmd.emit_mem  = 1'b1;
          cmd.emit_last = (idx_inc == stat.w_n) && !stat.nl2;
          if (idx_inc == stat.w_n) begin
            idx_nxt   = 6'd0;
            state_nxt = from_n2;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_WRD;
          end
        end
      end
      S_NL2: begin
        if (stat.out_free) begin
          cmd.emit_nl   = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
      idx_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> rtl/gtr_datapath.sv
module gtr_datapath
  import gtr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic [7:0] in_char,
  input  logic       in_end_of_input,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  input  gtr_cmd_t   cmd,
  output gtr_stat_t  stat
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [5:0] DEPTH = 6'(BUFFER_DEPTH);

  localparam logic [1:0] M_IND = 2'd0;
  localparam logic [1:0] M_WRD = 2'd1;
  localparam logic [1:0] M_SPC = 2'd2;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  function automatic logic [7:0] sat8(input logic [8:0] v);
    sat8 = v[8] ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [5:0] sat6(input logic [6:0] v);
    sat6 = v[6] ? 6'h3F : v[5:0];
  endfunction

  // configuration
  logic [4:0] lw_cfg_r, tw_cfg_r, lw, tw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_cfg_r <= 5'd31;
      tw_cfg_r <= 5'd8;
    end else if (cfg_we) begin
      if (cfg_index) tw_cfg_r <= cfg_data;
      else           lw_cfg_r <= cfg_data;
    end
  end

  assign lw = (lw_cfg_r == 5'd0) ? 5'd1 : lw_cfg_r;
  assign tw = (tw_cfg_r == 5'd0) ? 5'd1 : tw_cfg_r;

  // latched request
  logic [7:0] c_r;
  logic       eoi_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r   <= in_char;
      eoi_r <= in_end_of_input;
    end
  end

  // reflow state
  logic [1:0] mode_r, mode_nxt;
  logic [5:0] ic_r, ic_nxt, icol_r, icol_nxt, sc_r, sc_nxt, scol_r, scol_nxt;
  logic [5:0] wc_r, wc_nxt, pic_r, pic_nxt;
  logic [7:0] oc_r, oc_nxt, lnw_r, lnw_nxt;
  logic       flf_r, flf_nxt, dcf_r, dcf_nxt;

  logic is_sp, is_tab, is_nl, is_white, ends, cap, brk, ew;
  logic [7:0] oc1, oc_t, mod_op;
  logic [4:0] mod_rem_r, inc_t;
  logic [5:0] mod_try;

  assign is_sp    = (c_r == CH_SP);
  assign is_tab   = (c_r == CH_TAB);
  assign is_nl    = (c_r == CH_NL);
  assign is_white = is_sp || is_tab || is_nl;
  assign ends     = lnw_r inside {8'h2E, 8'h21, 8'h3F, 8'h22};
  assign cap      = c_r inside {[8'h41:8'h5A]};
  assign brk      = (oc_r >= {3'b000, lw});
  assign oc1      = brk ? sat8({3'b000, icol_r} + {3'b000, wc_r}) : oc_r;
  assign ew       = is_white || !((wc_r < {1'b0, lw}) && (wc_r < DEPTH));
  assign inc_t    = is_tab ? (tw - mod_rem_r) : 5'd1;

  // tab stop remainder, one dividend bit per step
  always_comb begin
    case (mode_r)
      M_IND:   mod_op = {2'b00, icol_r};
      M_WRD:   mod_op = oc1;
      default: mod_op = oc_r;
    endcase
  end

  assign mod_try = {mod_rem_r, mod_op[cmd.mod_bit]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_rem_r <= 5'd0;
    end else if (cmd.mod_step) begin
      mod_rem_r <= (mod_try >= {1'b0, tw}) ? 5'(mod_try - {1'b0, tw}) : mod_try[4:0];
    end
  end

  // emission plan
  always_comb begin
    stat.nl1    = 1'b0;
    stat.a_ind  = brk;
    stat.a_n    = 6'd0;
    stat.w_n    = 6'd0;
    stat.nl2    = 1'b0;
    stat.is_tab = is_tab && !eoi_r;
    if (eoi_r) begin
      if (wc_r != 6'd0) begin
        stat.nl1 = brk && !flf_r;
        stat.a_n = brk ? ic_r : sc_r;
        stat.w_n = wc_r;
      end
      stat.nl2 = (wc_r != 6'd0) || (sc_r != 6'd0);
    end else if (mode_r == M_IND) begin
      if (is_nl) begin
        stat.nl1 = (sc_r != 6'd0);
        stat.nl2 = 1'b1;
      end
    end else if (mode_r == M_WRD) begin
      if (ew) begin
        stat.nl1 = brk && !flf_r;
        stat.a_n = brk ? ic_r : sc_r;
        stat.w_n = wc_r;
      end
    end
  end

  // store writes of this step
  logic       ind_we, sp_we, wd_we;
  logic [5:0] ind_wa, sp_wa, wd_wa;
  logic [7:0] sp_wd;

  // next state of one step
  always_comb begin
    mode_nxt = mode_r;
    ic_nxt   = ic_r;
    icol_nxt = icol_r;
    sc_nxt   = sc_r;
    scol_nxt = scol_r;
    wc_nxt   = wc_r;
    pic_nxt  = pic_r;
    oc_nxt   = oc_r;
    lnw_nxt  = lnw_r;
    flf_nxt  = flf_r;
    dcf_nxt  = dcf_r;
    oc_t     = oc_r;
    ind_we   = 1'b0;
    sp_we    = 1'b0;
    wd_we    = 1'b0;
    ind_wa   = ic_r;
    sp_wa    = sc_r;
    wd_wa    = wc_r;
    sp_wd    = c_r;
    if (eoi_r) begin
      mode_nxt = M_IND;
      ic_nxt   = 6'd0;
      icol_nxt = 6'd0;
      sc_nxt   = 6'd0;
      scol_nxt = 6'd0;
      wc_nxt   = 6'd0;
      pic_nxt  = 6'd0;
      oc_nxt   = {3'b000, lw};
      lnw_nxt  = CH_SP;
      flf_nxt  = 1'b1;
      dcf_nxt  = 1'b0;
    end else if (mode_r == M_IND) begin
      if (is_sp || is_tab) begin
        if (({1'b0, icol_r} + {2'b00, inc_t} < {2'b00, lw}) && (ic_r < DEPTH)) begin
          ind_we   = 1'b1;
          ic_nxt   = ic_r + 6'd1;
          icol_nxt = icol_r + {1'b0, inc_t};
        end
      end else if (is_nl) begin
        sc_nxt   = 6'd0;
        scol_nxt = 6'd0;
        flf_nxt  = 1'b1;
        oc_nxt   = {3'b000, lw};
        ic_nxt   = 6'd0;
        icol_nxt = 6'd0;
      end else begin
        // extra space after a sentence end before a capital
        if (ends && cap) begin
          if (sc_r < DEPTH) begin
            sp_we  = 1'b1;
            sp_wd  = CH_SP;
            sc_nxt = sc_r + 6'd1;
          end
          scol_nxt = sat6({1'b0, scol_r} + 7'd1);
          oc_t     = sat8({1'b0, oc_r} + 9'd1);
        end
        if (wc_r < DEPTH) begin
          wd_we  = 1'b1;
          wc_nxt = wc_r + 6'd1;
        end
        lnw_nxt = c_r;
        oc_nxt  = sat8({1'b0, oc_t} + 9'd1);
        if (icol_r > pic_r) oc_nxt = {3'b000, lw};
        if (c_r == CH_DOT && icol_r == 6'd0) begin
          oc_nxt  = {3'b000, lw};
          dcf_nxt = 1'b1;
        end
        mode_nxt = M_WRD;
      end
    end else if (mode_r == M_WRD) begin
      if (ew) begin
        // place the word, then buffer the white
        if (brk) flf_nxt = 1'b0;
        sp_we    = 1'b1;
        sp_wa    = 6'd0;
        sc_nxt   = 6'd1;
        wc_nxt   = 6'd0;
        if (is_nl) begin
          sp_wd    = CH_SP;
          oc_t     = dcf_r ? {3'b000, lw} : oc1;
          pic_nxt  = icol_r;
          ic_nxt   = 6'd0;
          icol_nxt = 6'd0;
          scol_nxt = 6'd1;
          oc_nxt   = sat8({1'b0, oc_t} + 9'd1);
          dcf_nxt  = 1'b0;
          mode_nxt = M_IND;
        end else begin
          sp_wd    = is_white ? c_r : CH_SP;
          scol_nxt = {1'b0, inc_t};
          oc_t     = sat8({1'b0, oc1} + {4'b0000, inc_t});
          oc_nxt   = oc_t;
          mode_nxt = M_SPC;
          // word split: the byte starts the next word
          if (!is_white) begin
            wd_we    = 1'b1;
            wd_wa    = 6'd0;
            wc_nxt   = 6'd1;
            lnw_nxt  = c_r;
            oc_nxt   = sat8({1'b0, oc_t} + 9'd1);
            mode_nxt = M_WRD;
          end
        end
      end else begin
        wd_we   = 1'b1;
        wc_nxt  = wc_r + 6'd1;
        lnw_nxt = c_r;
        oc_nxt  = sat8({1'b0, oc_r} + 9'd1);
      end
    end else begin
      if (is_sp || is_tab) begin
        if (({1'b0, scol_r} + {2'b00, inc_t} < {2'b00, lw}) && (sc_r < DEPTH)) begin
          sp_we    = 1'b1;
          sc_nxt   = sc_r + 6'd1;
          scol_nxt = sat6({1'b0, scol_r} + {2'b00, inc_t});
          oc_nxt   = sat8({1'b0, oc_r} + {4'b0000, inc_t});
        end
      end else if (is_nl) begin
        if (dcf_r) oc_nxt = {3'b000, lw};
        pic_nxt  = icol_r;
        ic_nxt   = 6'd0;
        icol_nxt = 6'd0;
        sp_we    = 1'b1;
        sp_wa    = 6'd0;
        sp_wd    = CH_SP;
        sc_nxt   = 6'd1;
        scol_nxt = 6'd1;
        dcf_nxt  = 1'b0;
        mode_nxt = M_IND;
      end else begin
        if (wc_r < DEPTH) begin
          wd_we  = 1'b1;
          wc_nxt = wc_r + 6'd1;
        end
        lnw_nxt  = c_r;
        oc_nxt   = sat8({1'b0, oc_r} + 9'd1);
        mode_nxt = M_WRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IND;
      ic_r   <= 6'd0;
      icol_r <= 6'd0;
      sc_r   <= 6'd0;
      scol_r <= 6'd0;
      wc_r   <= 6'd0;
      pic_r  <= 6'd0;
      oc_r   <= 8'd31;
      lnw_r  <= CH_SP;
      flf_r  <= 1'b1;
      dcf_r  <= 1'b0;
    end else if (cmd.apply) begin
      mode_r <= mode_nxt;
      ic_r   <= ic_nxt;
      icol_r <= icol_nxt;
      sc_r   <= sc_nxt;
      scol_r <= scol_nxt;
      wc_r   <= wc_nxt;
      pic_r  <= pic_nxt;
      oc_r   <= oc_nxt;
      lnw_r  <= lnw_nxt;
      flf_r  <= flf_nxt;
      dcf_r  <= dcf_nxt;
    end
  end

  // indent, space and word stores
  logic [7:0] ind_mem [BUFFER_DEPTH];
  logic [7:0] sp_mem  [BUFFER_DEPTH];
  logic [7:0] wd_mem  [BUFFER_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.apply && ind_we) ind_mem[ind_wa[AW-1:0]] <= c_r;
    if (cmd.apply && sp_we)  sp_mem[sp_wa[AW-1:0]]   <= sp_wd;
    if (cmd.apply && wd_we)  wd_mem[wd_wa[AW-1:0]]   <= c_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      case (cmd.rd_src)
        SRC_IND: rd_data_r <= ind_mem[cmd.rd_idx[AW-1:0]];
        SRC_SPC: rd_data_r <= sp_mem[cmd.rd_idx[AW-1:0]];
        default: rd_data_r <= wd_mem[cmd.rd_idx[AW-1:0]];
      endcase
    end
  end

  // output register
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_nl || cmd.emit_mem) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_nl || cmd.emit_mem) begin
      out_char_r <= cmd.emit_nl ? CH_NL : rd_data_r;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

endmodule

>>> rtl/greedy_text_reflow_top.sv
// a request is accepted only in idle; the next one waits until its run is emitted and applied
// a plain byte takes one remainder step; a tab runs the remainder unit over all eight dividend bits
// each buffered byte emitted takes a read state and an emit state on the single store read port
// synchronous active-low reset clears all control state, line width 31, tab width 8
// store contents are not cleared; only entries below their counts are read
module greedy_text_reflow_top
  import gtr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);

  gtr_cmd_t  cmd;
  gtr_stat_t stat;

  // sequencer
  gtr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // reflow state, stores and output register
  gtr_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_char         (in_char),
    .in_end_of_input (in_end_of_input),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

>>> rtl/gtr_checker.sv
module gtr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_char,
  input logic       in_end_of_input,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last_of_run,
  input logic       cfg_we,
  input logic       cfg_index,
  input logic [4:0] cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last_of_run))
    else $error("stalled output changed");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // reset leaves no result pending
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // no new request while a run is still being delivered
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !in_ready)
    else $error("ready in the middle of a run");

endmodule

bind greedy_text_reflow_top gtr_checker u_chk (.*);
